// ===== hdl/ctk_pkg.sv =====
// ----------------------------------------------------------------------------
// ctk_pkg
// Shared types, codes and word tables for the character class tokenizer.
// ----------------------------------------------------------------------------
package ctk_pkg;

    // token class held between bytes
    typedef enum logic [1:0] {
        CLS_NONE = 2'd0,
        CLS_ID   = 2'd1,
        CLS_NUM  = 2'd2,
        CLS_OP   = 2'd3
    } t_class;

    // character class of one byte
    typedef enum logic [2:0] {
        EV_LETTER  = 3'd0,
        EV_DIGIT   = 3'd1,
        EV_OP      = 3'd2,
        EV_SPACE   = 3'd3,
        EV_INVALID = 3'd4
    } t_event;

    // error codes
    localparam logic ERR_INVALID_CHAR     = 1'b0;
    localparam logic ERR_LETTER_AFTER_NUM = 1'b1;

    // token kinds
    localparam logic [4:0] KIND_ID       = 5'd0;
    localparam logic [4:0] KIND_NUM      = 5'd1;
    localparam logic [4:0] KIND_OTHER_OP = 5'd2;
    localparam logic [4:0] KIND_OP_BASE  = 5'd3;
    localparam logic [4:0] KIND_KEY_BASE = 5'd15;

    localparam int WORD_BYTES = 5;
    localparam int OP_WORDS   = 12;
    localparam int KEY_WORDS  = 14;

    // words are right aligned: last character in the low byte
    localparam logic [39:0] OP_TEXT [OP_WORDS] = '{
        ";", "(", ")", ":=", "+", "-", "*", "/", ".", "=", "(*", "*)"
    };
    localparam logic [2:0] OP_LEN [OP_WORDS] = '{
        3'd1, 3'd1, 3'd1, 3'd2, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2
    };
    localparam logic [39:0] KEY_TEXT [KEY_WORDS] = '{
        "unit", "if", "then", "else", "while", "do", "read", "write",
        "let", "in", "proc", "true", "false", "not"
    };
    localparam logic [2:0] KEY_LEN [KEY_WORDS] = '{
        3'd4, 3'd2, 3'd4, 3'd4, 3'd5, 3'd2, 3'd4, 3'd5,
        3'd3, 3'd2, 3'd4, 3'd4, 3'd5, 3'd3
    };

    // handshake between lexer and result queue
    typedef struct packed {
        logic first;
        logic second;
    } t_push;

    function automatic t_event classify(input logic [7:0] c);
        t_event ev;
        case (c) inside
            ["A":"Z"], ["a":"z"]: ev = EV_LETTER;
            ["0":"9"]:            ev = EV_DIGIT;
            ":", "+", "=", ".", "(", ")", "[", "]", "*", "/", "-",
            8'h22, 8'h5C, 8'h27, ";":
                                  ev = EV_OP;
            " ", [8'd9:8'd13]:    ev = EV_SPACE;
            default:              ev = EV_INVALID;
        endcase
        return ev;
    endfunction

    // class table; a letter after a number is caught separately as an error
    function automatic t_class next_class(input t_class cls, input t_event ev);
        t_class nxt;
        case (ev)
            EV_LETTER: nxt = CLS_ID;
            EV_DIGIT:  nxt = (cls == CLS_ID) ? CLS_ID : CLS_NUM;
            EV_OP:     nxt = CLS_OP;
            default:   nxt = CLS_NONE;
        endcase
        return nxt;
    endfunction

    // prefix byte k holds the token's k-th character
    function automatic logic word_hit(input logic [39:0] text, input logic [2:0] len,
                                      input logic [63:0] prefix, input logic [31:0] count,
                                      input int unsigned mpb);
        logic hit;
        int   idx;
        hit = (count == 32'(len)) && (32'(len) <= mpb);
        for (int k = 0; k < WORD_BYTES; k++) begin
            idx = int'(len) - 1 - k;
            if (k < int'(len)) begin
                if (text[8*idx +: 8] != prefix[8*k +: 8]) hit = 1'b0;
            end
        end
        return hit;
    endfunction

    function automatic logic [4:0] kind_of(input t_class cls, input logic [63:0] prefix,
                                           input logic [31:0] count, input int unsigned mpb);
        logic [4:0] kind;
        if (cls == CLS_NUM) begin
            kind = KIND_NUM;
        end else if (cls == CLS_OP) begin
            kind = KIND_OTHER_OP;
            for (int i = OP_WORDS - 1; i >= 0; i--) begin
                if (word_hit(OP_TEXT[i], OP_LEN[i], prefix, count, mpb))
                    kind = KIND_OP_BASE + 5'(i);
            end
        end else begin
            kind = KIND_ID;
            for (int i = KEY_WORDS - 1; i >= 0; i--) begin
                if (word_hit(KEY_TEXT[i], KEY_LEN[i], prefix, count, mpb))
                    kind = KIND_KEY_BASE + 5'(i);
            end
        end
        return kind;
    endfunction

endpackage

// ===== hdl/char_class_tokenizer.sv =====
// ----------------------------------------------------------------------------
// char_class_tokenizer
// Byte serial lexer: classifies characters, tracks identifier, number and
// operator tokens, and reports each finished token or a lexing error.
//
//   channel  direction  handshake           payload
//   input    in         i_valid / o_stall   i_input_byte, i_end_of_stream
//   result   out        o_valid / i_stall   o_is_error ... o_last_of_run
//
// One byte is accepted per cycle while the result queue has room; a result
// passes the input register, then the result queue, before it appears.
// A byte gives up to two results, but each token or error is reported once,
// so results never outnumber bytes and an unstalled queue keeps one byte/cycle.
// Reset is synchronous, active low, and clears all token state.
// A stall on the result side fills the four entry queue until fewer than two entries are free, then stalls input.
// ----------------------------------------------------------------------------
module char_class_tokenizer #(
    parameter int MATCH_PREFIX_BYTES = 5,
    parameter int LENGTH_BITS        = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [7:0]             i_input_byte,
    input  logic                   i_end_of_stream,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_is_error,
    output logic                   o_error_code,
    output logic [4:0]             o_token_kind,
    output logic [31:0]            o_token_start,
    output logic [LENGTH_BITS-1:0] o_token_length,
    output logic                   o_last_of_run
);
    import ctk_pkg::*;

    localparam int RES_W = LENGTH_BITS + 40;

    typedef struct packed {
        logic                   is_error;
        logic                   error_code;
        logic [4:0]             kind;
        logic [31:0]            start;
        logic [LENGTH_BITS-1:0] length;
        logic                   last;
    } t_result;

    logic             r_in_valid, n_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_eos;
    logic             room, fire, accept;
    t_push            push;
    logic [RES_W-1:0] res0, res1, head_data;
    t_result          head;

    // input register
    assign fire    = r_in_valid && room;
    assign o_stall = r_in_valid && !room;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (fire)   n_in_valid = 1'b0;
        if (accept) n_in_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
        if (accept) begin
            r_in_byte <= i_input_byte;
            r_in_eos  <= i_end_of_stream;
        end
    end

    ctk_lexer #(
        .MATCH_PREFIX_BYTES (MATCH_PREFIX_BYTES),
        .LENGTH_BITS        (LENGTH_BITS)
    ) u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .i_eos   (r_in_eos),
        .o_push  (push),
        .o_res0  (res0),
        .o_res1  (res1)
    );

    ctk_result_fifo #(
        .DATA_W (RES_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data0 (res0),
        .i_data1 (res1),
        .i_pop   (!i_stall),
        .o_valid (o_valid),
        .o_data  (head_data),
        .o_room  (room)
    );

    // result fields
    assign head           = head_data;
    assign o_is_error     = head.is_error;
    assign o_error_code   = head.error_code;
    assign o_token_kind   = head.kind;
    assign o_token_start  = head.start;
    assign o_token_length = head.length;
    assign o_last_of_run  = head.last;

endmodule

// ===== hdl/ctk_lexer.sv =====
// ----------------------------------------------------------------------------
// ctk_lexer
// Token state machine: classifies one byte per fire and emits up to two
// results (finished token and end of stream flush, or one error).
// ----------------------------------------------------------------------------
module ctk_lexer #(
    parameter int MATCH_PREFIX_BYTES = 5,
    parameter int LENGTH_BITS        = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_fire,
    input  logic [7:0]              i_byte,
    input  logic                    i_eos,
    output ctk_pkg::t_push          o_push,
    output logic [LENGTH_BITS+39:0] o_res0,
    output logic [LENGTH_BITS+39:0] o_res1
);
    import ctk_pkg::*;

    localparam int PW = MATCH_PREFIX_BYTES * 8;

    typedef struct packed {
        logic                   is_error;
        logic                   error_code;
        logic [4:0]             kind;
        logic [31:0]            start;
        logic [LENGTH_BITS-1:0] length;
        logic                   last;
    } t_result;

    t_class                 r_class, n_class, nxt;
    logic [PW-1:0]          r_prefix, n_prefix;
    logic [LENGTH_BITS-1:0] r_count, n_count;
    logic [31:0]            r_offset, n_offset;
    logic [31:0]            r_pos, n_pos;
    logic                   r_halted, n_halted;

    t_event     ev;
    logic       bad;
    logic       emit_change, emit_eos;
    logic [4:0] kind_cur;
    t_result    tok_a, tok_b, res0, res1;
    t_push      push;

    assign ev       = classify(i_byte);
    assign nxt      = next_class(r_class, ev);
    assign bad      = (ev == EV_INVALID) || (ev == EV_LETTER && r_class == CLS_NUM);
    assign kind_cur = kind_of(r_class, 64'(r_prefix), 32'(r_count), MATCH_PREFIX_BYTES);

    // next state and results
    always_comb begin
        n_class     = r_class;
        n_prefix    = r_prefix;
        n_count     = r_count;
        n_offset    = r_offset;
        n_pos       = r_pos;
        n_halted    = r_halted;
        emit_change = 1'b0;
        emit_eos    = 1'b0;
        tok_a       = '0;
        tok_b       = '0;
        res0        = '0;
        res1        = '0;
        push        = '0;

        // finished token before the class change
        tok_a.kind   = kind_cur;
        tok_a.start  = r_offset;
        tok_a.length = r_count;

        if (i_fire) begin
            if (r_halted) begin
                // ignore bytes until end of stream restarts everything
                if (i_eos) begin
                    n_class  = CLS_NONE;
                    n_prefix = '0;
                    n_count  = '0;
                    n_offset = '0;
                    n_pos    = '0;
                    n_halted = 1'b0;
                end
            end else if (bad) begin
                res0.is_error   = 1'b1;
                res0.error_code = (ev == EV_INVALID) ? ERR_INVALID_CHAR
                                                     : ERR_LETTER_AFTER_NUM;
                res0.start      = r_pos;
                res0.last       = 1'b1;
                push.first      = 1'b1;
                n_pos           = r_pos + 32'd1;
                n_halted        = 1'b1;
                if (i_eos) begin
                    n_class  = CLS_NONE;
                    n_prefix = '0;
                    n_count  = '0;
                    n_offset = '0;
                    n_pos    = '0;
                    n_halted = 1'b0;
                end
            end else begin
                n_pos = r_pos + 32'd1;
                if (nxt == r_class) begin
                    // extend the token, keep first bytes for matching
                    for (int k = 0; k < MATCH_PREFIX_BYTES; k++) begin
                        if (r_count == LENGTH_BITS'(k))
                            n_prefix[8*k +: 8] = r_prefix[8*k +: 8] | i_byte;
                    end
                    if (r_count != '1) n_count = r_count + LENGTH_BITS'(1);
                end else begin
                    emit_change = (r_class != CLS_NONE);
                    n_class     = nxt;
                    n_prefix    = PW'(i_byte);
                    n_count     = LENGTH_BITS'(1);
                    n_offset    = r_pos;
                end
                if (i_eos) begin
                    // flush the pending token, then restart
                    emit_eos     = (n_class != CLS_NONE);
                    tok_b.kind   = kind_of(n_class, 64'(n_prefix), 32'(n_count),
                                           MATCH_PREFIX_BYTES);
                    tok_b.start  = n_offset;
                    tok_b.length = n_count;
                    n_class      = CLS_NONE;
                    n_prefix     = '0;
                    n_count      = '0;
                    n_offset     = '0;
                    n_pos        = '0;
                end
                // pack results: first one always in slot 0
                res0        = emit_change ? tok_a : tok_b;
                res0.last   = !(emit_change && emit_eos);
                res1        = tok_b;
                res1.last   = 1'b1;
                push.first  = emit_change || emit_eos;
                push.second = emit_change && emit_eos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class  <= CLS_NONE;
            r_prefix <= '0;
            r_count  <= '0;
            r_offset <= '0;
            r_pos    <= '0;
            r_halted <= 1'b0;
        end else begin
            r_class  <= n_class;
            r_prefix <= n_prefix;
            r_count  <= n_count;
            r_offset <= n_offset;
            r_pos    <= n_pos;
            r_halted <= n_halted;
        end
    end

    assign o_push = push;
    assign o_res0 = res0;
    assign o_res1 = res1;

endmodule

// ===== hdl/ctk_result_fifo.sv =====
// ----------------------------------------------------------------------------
// ctk_result_fifo
// Four entry result queue: takes up to two words per cycle, gives one.
// ----------------------------------------------------------------------------
module ctk_result_fifo #(
    parameter int DATA_W = 56
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ctk_pkg::t_push      i_push,
    input  logic [DATA_W-1:0]   i_data0,
    input  logic [DATA_W-1:0]   i_data1,
    input  logic                i_pop,
    output logic                o_valid,
    output logic [DATA_W-1:0]   o_data,
    output logic                o_room
);
    import ctk_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [AW-1:0]     r_wr, n_wr, r_rd, n_rd;
    logic [AW:0]       r_cnt, n_cnt;
    logic [AW:0]       pushes;
    logic              pop;

    assign pop    = i_pop && (r_cnt != '0);
    assign pushes = (AW+1)'(i_push.first) + (AW+1)'(i_push.second);
    assign n_wr   = r_wr + AW'(pushes);
    assign n_rd   = r_rd + AW'(pop);
    assign n_cnt  = r_cnt + pushes - (AW+1)'(pop);

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push.first)  r_mem[r_wr]          <= i_data0;
        if (i_push.second) r_mem[r_wr + AW'(1)] <= i_data1;
    end

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    // room for two more words
    assign o_room  = (r_cnt <= (AW+1)'(DEPTH - 2));

endmodule

// ===== hdl/ctk_checker.sv =====
// ----------------------------------------------------------------------------
// ctk_checker
// Port level checks for the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module ctk_checker #(
    parameter int LENGTH_BITS = 16
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_valid,
    input logic                   o_stall,
    input logic [7:0]             i_input_byte,
    input logic                   i_end_of_stream,
    input logic                   o_valid,
    input logic                   i_stall,
    input logic                   o_is_error,
    input logic                   o_error_code,
    input logic [4:0]             o_token_kind,
    input logic [31:0]            o_token_start,
    input logic [LENGTH_BITS-1:0] o_token_length,
    input logic                   o_last_of_run
);

    // a stalled input word holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_input_byte)
            && $stable(i_end_of_stream))
        else $error("stalled input word changed");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_token_start)
            && $stable(o_token_kind) && $stable(o_is_error)
            && $stable(o_token_length) && $stable(o_last_of_run))
        else $error("stalled result changed");

    // error reports carry no kind and no length
    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_error |-> o_token_kind == 5'd0 && o_token_length == '0
            && o_last_of_run)
        else $error("error report with token fields");

    // tokens have a length, a known kind and no error code
    a_tok_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_error |-> !o_error_code && o_token_length != '0
            && o_token_kind <= 5'd28)
        else $error("malformed token result");

    // reset empties the result side and clears the input stall
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("results present after reset");

endmodule

bind char_class_tokenizer ctk_checker #(.LENGTH_BITS(LENGTH_BITS)) u_ctk_checker (.*);

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the character class tokenizer. A directed table
// covers reset, keyword and operator matches, both error kinds, the halt and
// restart on end of stream, and invalid bytes 0 and 255. Random token
// streams come last: keywords, near misses, identifiers, numbers, operator
// runs, broken sequences and noise bytes. Every result is checked against a
// lexer model kept inside the bench, or against the expected result of a typed
// directed row. Both sides idle and stall at random.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ctk_pkg::*;

    localparam int MPB        = 5;
    localparam int LEN_BITS   = 16;
    localparam int LEN_MAX    = (1 << LEN_BITS) - 1;
    localparam int RAND_BYTES = 2000;
    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_WAIT  = 16;

    // one result word
    typedef struct packed {
        logic        is_error;
        logic        error_code;
        logic [4:0]  kind;
        logic [31:0] start;
        logic [15:0] length;
        logic        last;
    } tok_res_t;

    // one directed stimulus row; typed rows carry their own expected result
    typedef struct {
        logic [7:0] ch;
        logic       eos;
        bit         typed;
        tok_res_t   want;
    } dir_row_t;

    localparam tok_res_t NO_RES = '0;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic [7:0]          i_input_byte = '0;
    logic                i_end_of_stream = 1'b0;
    logic                i_stall = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic                o_is_error;
    logic                o_error_code;
    logic [4:0]          o_token_kind;
    logic [31:0]         o_token_start;
    logic [LEN_BITS-1:0] o_token_length;
    logic                o_last_of_run;

    // word tables for kind refinement
    string op_spell [12] = '{";", "(", ")", ":=", "+", "-", "*", "/", ".", "=", "(*", "*)"};
    string key_spell [14] = '{"unit", "if", "then", "else", "while", "do", "read", "write",
                              "let", "in", "proc", "true", "false", "not"};
    logic [7:0] op_chars [15] = '{":", "+", "=", ".", "(", ")", "[", "]", "*", "/", "-",
                                  8'h22, 8'h5C, 8'h27, ";"};

    // lexer model state
    t_class      lx_class;
    logic [63:0] lx_prefix;
    logic [31:0] lx_count;
    logic [31:0] lx_start;
    logic [31:0] lx_pos;
    bit          lx_halted;

    tok_res_t    pend_results [$];
    dir_row_t    dir_rows [$];

    int unsigned mismatches   = 0;
    int unsigned live_bytes   = 0;
    int unsigned halted_bytes = 0;
    int unsigned tokens_seen  = 0;
    int unsigned errors_seen  = 0;
    int unsigned calm_left    = 0;
    int unsigned stall_left   = 0;
    int unsigned idle_cycles  = 0;

    char_class_tokenizer #(
        .MATCH_PREFIX_BYTES(MPB),
        .LENGTH_BITS       (LEN_BITS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_input_byte   (i_input_byte),
        .i_end_of_stream(i_end_of_stream),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_is_error     (o_is_error),
        .o_error_code   (o_error_code),
        .o_token_kind   (o_token_kind),
        .o_token_start  (o_token_start),
        .o_token_length (o_token_length),
        .o_last_of_run  (o_last_of_run)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // lexer model
    // ------------------------------------------------------------------
    function automatic tok_res_t tok_at(input logic [4:0] kind, input logic [31:0] at,
                                        input logic [15:0] len);
        tok_res_t r;
        r        = '0;
        r.kind   = kind;
        r.start  = at;
        r.length = len;
        r.last   = 1'b1;
        return r;
    endfunction

    function automatic tok_res_t err_at(input logic code, input logic [31:0] at);
        tok_res_t r;
        r            = '0;
        r.is_error   = 1'b1;
        r.error_code = code;
        r.start      = at;
        r.last       = 1'b1;
        return r;
    endfunction

    function automatic void lex_clear();
        lx_class  = CLS_NONE;
        lx_prefix = '0;
        lx_count  = '0;
        lx_start  = '0;
        lx_pos    = '0;
        lx_halted = 1'b0;
    endfunction

    function automatic t_event char_event(input logic [7:0] c);
        if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) return EV_LETTER;
        if (c >= "0" && c <= "9") return EV_DIGIT;
        foreach (op_chars[i]) begin
            if (op_chars[i] == c) return EV_OP;
        end
        if (c == " " || (c >= 8'd9 && c <= 8'd13)) return EV_SPACE;
        return EV_INVALID;
    endfunction

    // true when the pending token spells w exactly, within the match window
    function automatic bit spells(input string w);
        if (w.len() != lx_count || w.len() > MPB) return 1'b0;
        for (int k = 0; k < w.len(); k++) begin
            if (lx_prefix[8*k +: 8] != w.getc(k)) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [4:0] pending_kind();
        if (lx_class == CLS_NUM) return KIND_NUM;
        if (lx_class == CLS_OP) begin
            for (int i = 0; i < 12; i++) begin
                if (spells(op_spell[i])) return KIND_OP_BASE + 5'(i);
            end
            return KIND_OTHER_OP;
        end
        for (int i = 0; i < 14; i++) begin
            if (spells(key_spell[i])) return KIND_KEY_BASE + 5'(i);
        end
        return KIND_ID;
    endfunction

    function automatic tok_res_t pending_token();
        tok_res_t r;
        r      = tok_at(pending_kind(), lx_start, 16'(lx_count));
        r.last = 1'b0;
        return r;
    endfunction

    // advance the model by one byte; returns how many results it causes
    function automatic int lex_step(input logic [7:0] c, input logic eos,
                                    output tok_res_t res [2]);
        t_event      ev;
        t_class      nxt;
        logic [31:0] at;
        int          n;
        n      = 0;
        res[0] = NO_RES;
        res[1] = NO_RES;
        if (lx_halted) begin
            if (eos) lex_clear();
            return 0;
        end
        at     = lx_pos;
        lx_pos = lx_pos + 32'd1;
        ev     = char_event(c);

        // invalid byte or letter glued to a number: report and halt
        if (ev == EV_INVALID || (ev == EV_LETTER && lx_class == CLS_NUM)) begin
            res[0]    = err_at(ev == EV_INVALID ? ERR_INVALID_CHAR : ERR_LETTER_AFTER_NUM, at);
            lx_halted = 1'b1;
            if (eos) lex_clear();
            return 1;
        end

        case (ev)
            EV_LETTER: nxt = CLS_ID;
            EV_DIGIT:  nxt = (lx_class == CLS_ID) ? CLS_ID : CLS_NUM;
            EV_OP:     nxt = CLS_OP;
            default:   nxt = CLS_NONE;
        endcase

        if (nxt == lx_class) begin
            if (lx_count < MPB) lx_prefix = lx_prefix | (64'(c) << (8 * lx_count));
            if (lx_count < LEN_MAX) lx_count = lx_count + 32'd1;
        end else begin
            if (lx_class != CLS_NONE) begin
                res[n] = pending_token();
                n      = n + 1;
            end
            lx_class  = nxt;
            lx_prefix = 64'(c);
            lx_count  = 32'd1;
            lx_start  = at;
        end

        // end of stream flushes the open token
        if (eos) begin
            if (lx_class != CLS_NONE) begin
                res[n] = pending_token();
                n      = n + 1;
            end
            lex_clear();
        end
        if (n > 0) res[n-1].last = 1'b1;
        return n;
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    // gap before the next word: calm stretches, mostly short gaps, few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm_left = $urandom_range(20, 120);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    task automatic send_word(input logic [7:0] c, input logic eos, input bit typed,
                             input tok_res_t want);
        int unsigned gap;
        tok_res_t    got [2];
        int          n;
        gap = pick_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_input_byte    <= c;
        i_end_of_stream <= eos;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        // accepted at this edge
        if (lx_halted) halted_bytes++;
        else live_bytes++;
        n = lex_step(c, eos, got);
        if (typed) begin
            pend_results.push_back(want);
        end else begin
            for (int k = 0; k < n; k++) pend_results.push_back(got[k]);
        end
    endtask

    task automatic put_byte(input logic [7:0] c, input logic eos);
        send_word(c, eos, 1'b0, NO_RES);
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) put_byte(s.getc(k), 1'b0);
    endtask

    task automatic add_row(input logic [7:0] c, input logic eos, input bit typed,
                           input tok_res_t want);
        dir_row_t r;
        r.ch    = c;
        r.eos   = eos;
        r.typed = typed;
        r.want  = want;
        dir_rows.push_back(r);
    endtask

    function automatic logic [7:0] any_letter();
        int unsigned r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'("A" + r) : 8'("a" + r - 26);
    endfunction

    function automatic logic [7:0] any_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] any_space();
        int unsigned r;
        r = $urandom_range(0, 5);
        return (r == 0) ? 8'h20 : 8'(8 + r);
    endfunction

    function automatic logic [7:0] any_invalid();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (char_event(c) != EV_INVALID);
        return c;
    endfunction

    // random token streams, mostly well formed
    task automatic random_streams(input int unsigned target);
        int unsigned base;
        int unsigned pick;
        string       w;
        logic [7:0]  c;
        base = live_bytes;
        while (live_bytes - base < target) begin
            pick = $urandom_range(0, 99);
            // a halted stream is mostly noise; end it soon
            if (lx_halted && $urandom_range(0, 2) == 0) pick = 97;
            if (pick < 20) begin
                send_text(key_spell[$urandom_range(0, 13)]);
            end else if (pick < 34) begin
                send_text(op_spell[$urandom_range(0, 11)]);
            end else if (pick < 42) begin
                // near miss on a keyword
                w = key_spell[$urandom_range(0, 13)];
                case ($urandom_range(0, 2))
                    0:       w = {w, "s"};
                    1:       w.putc(0, w.getc(0) ^ 8'h20);
                    default: w = w.substr(0, w.len() - 2);
                endcase
                send_text(w);
            end else if (pick < 52) begin
                put_byte(any_letter(), 1'b0);
                repeat ($urandom_range(0, 7))
                    put_byte($urandom_range(0, 1) ? any_letter() : any_digit(), 1'b0);
            end else if (pick < 62) begin
                repeat ($urandom_range(1, 6)) put_byte(any_digit(), 1'b0);
            end else if (pick < 71) begin
                repeat ($urandom_range(1, 6)) put_byte(op_chars[$urandom_range(0, 14)], 1'b0);
            end else if (pick < 79) begin
                repeat ($urandom_range(1, 3)) put_byte(any_space(), 1'b0);
            end else if (pick < 83) begin
                put_byte(any_digit(), 1'b0);
                put_byte(any_letter(), 1'b0);
            end else if (pick < 87) begin
                put_byte(any_invalid(), 1'b0);
            end else if (pick < 94) begin
                put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end else begin
                case ($urandom_range(0, 4))
                    0:       c = any_letter();
                    1:       c = any_digit();
                    2:       c = op_chars[$urandom_range(0, 14)];
                    3:       c = any_space();
                    default: c = 8'($urandom_range(0, 255));
                endcase
                put_byte(c, 1'b1);
            end
            if ($urandom_range(0, 1) == 1) put_byte(any_space(), 1'b0);
        end
        put_byte(8'h20, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    // receiver stall: alternating stretches, a few long stalls
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
                    i_stall    <= 1'b0;
                    stall_left <= $urandom_range(0, 7);
                end
                10, 11, 12, 13, 14, 15, 16: begin
                    i_stall    <= 1'b1;
                    stall_left <= $urandom_range(0, 2);
                end
                17, 18: begin
                    i_stall    <= 1'b0;
                    stall_left <= $urandom_range(20, 80);
                end
                default: begin
                    i_stall    <= 1'b1;
                    stall_left <= $urandom_range(10, 40);
                end
            endcase
        end
    end

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("%0t ns mismatch: %s", $time, what);
    endtask

    task automatic cmp_field(input string name, input logic [31:0] got,
                             input logic [31:0] want, input logic [31:0] at);
        if (got !== want)
            flag_mismatch($sformatf("%s got %0d want %0d (expected start %0d)",
                                    name, got, want, at));
    endtask

    task automatic check_result();
        tok_res_t want;
        if (o_is_error) errors_seen++;
        else tokens_seen++;
        if (pend_results.size() == 0) begin
            flag_mismatch($sformatf("unexpected word: error %0b kind %0d start %0d length %0d",
                                    o_is_error, o_token_kind, o_token_start, o_token_length));
            return;
        end
        want = pend_results.pop_front();
        cmp_field("is_error", 32'(o_is_error), 32'(want.is_error), want.start);
        cmp_field("error_code", 32'(o_error_code), 32'(want.error_code), want.start);
        cmp_field("token_kind", 32'(o_token_kind), 32'(want.kind), want.start);
        cmp_field("token_start", o_token_start, want.start, want.start);
        cmp_field("token_length", 32'(o_token_length), 32'(want.length), want.start);
        cmp_field("last_of_run", 32'(o_last_of_run), 32'(want.last), want.start);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) check_result();
    end

    // watchdog: cycles in which neither side moves a word
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results pending",
                     IDLE_LIMIT, pend_results.size());
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        lex_clear();

        // directed rows; positions restart after each end of stream
        add_row("i", 1'b0, 1'b0, NO_RES);
        add_row("f", 1'b0, 1'b0, NO_RES);
        add_row(" ", 1'b0, 1'b1, tok_at(KIND_KEY_BASE + 5'd1, 0, 2));          // if
        add_row(":", 1'b0, 1'b0, NO_RES);
        add_row("=", 1'b0, 1'b0, NO_RES);
        add_row("9", 1'b0, 1'b1, tok_at(KIND_OP_BASE + 5'd3, 3, 2));           // :=
        add_row("a", 1'b0, 1'b1, err_at(ERR_LETTER_AFTER_NUM, 6));
        add_row("z", 1'b0, 1'b0, NO_RES);                                       // halted
        add_row("q", 1'b1, 1'b0, NO_RES);                                       // restart
        add_row(8'h00, 1'b0, 1'b1, err_at(ERR_INVALID_CHAR, 0));
        add_row(" ", 1'b1, 1'b0, NO_RES);
        add_row(8'hFF, 1'b1, 1'b1, err_at(ERR_INVALID_CHAR, 0));
        add_row("(", 1'b0, 1'b0, NO_RES);
        add_row("*", 1'b1, 1'b1, tok_at(KIND_OP_BASE + 5'd10, 0, 2));          // (*
        add_row("w", 1'b0, 1'b0, NO_RES);
        add_row("h", 1'b0, 1'b0, NO_RES);
        add_row("i", 1'b0, 1'b0, NO_RES);
        add_row("l", 1'b0, 1'b0, NO_RES);
        add_row("e", 1'b0, 1'b0, NO_RES);
        add_row(";", 1'b0, 1'b1, tok_at(KIND_KEY_BASE + 5'd4, 0, 5));          // while
        add_row("x", 1'b1, 1'b0, NO_RES);                                       // two results
        add_row("7", 1'b0, 1'b0, NO_RES);
        add_row(8'h80, 1'b1, 1'b1, err_at(ERR_INVALID_CHAR, 1));
        add_row("[", 1'b1, 1'b1, tok_at(KIND_OTHER_OP, 0, 1));
        add_row(8'h09, 1'b1, 1'b0, NO_RES);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].ch, dir_rows[i].eos, dir_rows[i].typed, dir_rows[i].want);

        random_streams(RAND_BYTES);
        i_valid <= 1'b0;

        // drain, then give a stray word time to show up
        while (pend_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        $display("covered %0d live bytes and %0d bytes while halted",
                 live_bytes, halted_bytes);
        $display("checked %0d tokens and %0d error reports, %0d mismatches",
                 tokens_seen, errors_seen, mismatches);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
